// ===== rtl/sgr_pkg.sv =====
// Shared types and constants for the stream group reverser.
`default_nettype none

package sgr_pkg;

  // Fixed widths of the stream words and the configuration register
  localparam int VALUE_W     = 16;
  localparam int CFG_W       = 5;
  // Element count width, wide enough for the largest group the 5-bit size register can set (31)
  localparam int GROUP_CNT_W = 7;

  // Group command passed from the front end to the back end
  typedef struct packed {
    logic                   bank;
    logic [GROUP_CNT_W-1:0] count;
    logic                   reverse;
    logic                   last;
  } cmd_t;

  // Buffer bank release from the back end to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // One result word waiting in the output stage
  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic               run_last;
    logic               list_last;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/sgr_if.sv =====
// Stream and configuration channel interfaces of the stream group reverser.
`default_nettype none

// Input element channel
interface sgr_in_if;
  logic                        valid;
  logic                        ready;
  logic [sgr_pkg::VALUE_W-1:0] item_value;
  logic                        list_end;

  modport source (output valid, output item_value, output list_end, input ready);
  modport sink   (input valid, input item_value, input list_end, output ready);
endinterface

// Result channel
interface sgr_out_if;
  logic                        valid;
  logic                        ready;
  logic [sgr_pkg::VALUE_W-1:0] out_value;
  logic                        run_last;
  logic                        list_last;

  modport source (output valid, output out_value, output run_last, output list_last,
                  input ready);
  modport sink   (input valid, input out_value, input run_last, input list_last,
                  output ready);
endinterface

// Group size register write channel
interface sgr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sgr_pkg::CFG_W-1:0] group_size;

  modport source (output valid, output group_size, input ready);
  modport sink   (input valid, input group_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/sgr_front.sv =====
// Front end: takes input words, fills a buffer bank and issues group commands.
`default_nettype none

module sgr_front #(
  parameter int MAX_GROUP  = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  sgr_in_if.sink            in_i,
  sgr_cfg_if.sink           cfg_i,
  output sgr_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  wire logic         cmd_ready_i,
  input  wire sgr_pkg::rel_t rel_i,
  output logic              mem_we_o,
  output logic [(MAX_GROUP > 1 ? $clog2(MAX_GROUP) : 1):0] mem_waddr_o,
  output logic [VALUE_BITS-1:0] mem_wdata_o
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = sgr_pkg::GROUP_CNT_W;

  logic [sgr_pkg::CFG_W-1:0] group_size_q;
  logic [CW-1:0]             fill_q, fill_d;
  logic                      wbank_q, wbank_d;
  logic [1:0]                busy_q, busy_d;

  logic [CW-1:0]             gs_ext;
  logic [CW-1:0]             size_eff;
  logic [CW-1:0]             held;
  logic                      accept;
  logic                      full_grp;
  logic                      emit;
  logic [VALUE_BITS+sgr_pkg::VALUE_W-1:0] wext;

  // Config register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= sgr_pkg::CFG_W'(2);
    end else if (cfg_i.valid) begin
      group_size_q <= cfg_i.group_size;
    end
  end

  // Effective group size: zero acts as one, large values clamp to the buffer depth
  always_comb begin
    gs_ext = CW'(group_size_q);
    if (group_size_q == '0) begin
      size_eff = CW'(1);
    end else if (gs_ext > CW'(MAX_GROUP)) begin
      size_eff = CW'(MAX_GROUP);
    end else begin
      size_eff = gs_ext;
    end
  end

  // Accept while the current bank is free and the command queue has room
  assign in_i.ready = !busy_q[wbank_q] && cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign held       = fill_q + CW'(1);
  assign full_grp   = held >= size_eff;
  assign emit       = accept && (full_grp || in_i.list_end);

  // Buffer write of each accepted word
  assign wext        = {{VALUE_BITS{1'b0}}, in_i.item_value};
  assign mem_we_o    = accept;
  assign mem_waddr_o = {wbank_q, fill_q[AW-1:0]};
  assign mem_wdata_o = wext[VALUE_BITS-1:0];

  // Group command: full groups go out reversed, a short tail in order
  assign cmd_valid_o   = emit;
  assign cmd_o.bank    = wbank_q;
  assign cmd_o.count   = held;
  assign cmd_o.reverse = full_grp;
  assign cmd_o.last    = in_i.list_end;

  // Fill count, bank select and bank busy flags
  always_comb begin
    fill_d  = fill_q;
    wbank_d = wbank_q;
    busy_d  = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (emit) begin
      busy_d[wbank_q] = 1'b1;
      wbank_d         = !wbank_q;
      fill_d          = '0;
    end else if (accept) begin
      fill_d = held;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sgr_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
`default_nettype none

module sgr_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sgr_pkg::cmd_t push_cmd_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output sgr_pkg::cmd_t      pop_cmd_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);

  sgr_pkg::cmd_t ent_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_cmd_o    = ent_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= push_cmd_i;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sgr_back.sv =====
// Back end: holds the two-bank buffer, replays groups and stages the results.
`default_nettype none

module sgr_back #(
  parameter int MAX_GROUP  = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire sgr_pkg::cmd_t cmd_i,
  input  wire logic         cmd_valid_i,
  output logic              cmd_ready_o,
  output sgr_pkg::rel_t     rel_o,
  input  wire logic         mem_we_i,
  input  wire logic [(MAX_GROUP > 1 ? $clog2(MAX_GROUP) : 1):0] mem_waddr_i,
  input  wire logic [VALUE_BITS-1:0] mem_wdata_i,
  sgr_out_if.source         out_o
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = sgr_pkg::GROUP_CNT_W;

  // Two banks of group buffer
  logic [VALUE_BITS-1:0] mem [2**(AW+1)];

  logic          act_q, act_d;
  logic          bank_q, bank_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          rev_q, rev_d;
  logic          last_q, last_d;

  logic                  rd_q, rd_run_q, rd_list_q;
  logic [VALUE_BITS-1:0] rdata_q;
  logic [VALUE_BITS+sgr_pkg::VALUE_W-1:0] rext;

  sgr_pkg::out_word_t ob_q [2];
  sgr_pkg::out_word_t ob_in;
  logic               obw_q, obr_q;
  logic [1:0]         obc_q;
  logic [1:0]         obc_after;
  logic               pop;
  logic               issue;
  logic               load;
  logic               final_rd;

  // Output stage handshake
  assign pop             = out_o.valid && out_o.ready;
  assign out_o.valid     = obc_q != 2'd0;
  assign out_o.out_value = ob_q[obr_q].out_value;
  assign out_o.run_last  = ob_q[obr_q].run_last;
  assign out_o.list_last = ob_q[obr_q].list_last;

  // Issue a read only when the output stage will have room for it
  assign obc_after = obc_q - {1'b0, pop};
  assign issue     = act_q && ((obc_after + {1'b0, rd_q}) < 2'd2);
  assign final_rd  = rem_q == CW'(1);
  assign load      = !act_q && cmd_valid_i;

  assign cmd_ready_o = !act_q;
  assign rel_o.valid = issue && final_rd;
  assign rel_o.bank  = bank_q;

  // Group replay sequencer
  always_comb begin
    act_d  = act_q;
    bank_d = bank_q;
    pos_d  = pos_q;
    rem_d  = rem_q;
    rev_d  = rev_q;
    last_d = last_q;
    if (load) begin
      act_d  = 1'b1;
      bank_d = cmd_i.bank;
      rem_d  = cmd_i.count;
      rev_d  = cmd_i.reverse;
      last_d = cmd_i.last;
      pos_d  = cmd_i.reverse ? AW'(cmd_i.count - CW'(1)) : '0;
    end else if (issue) begin
      rem_d = rem_q - CW'(1);
      pos_d = rev_q ? pos_q - AW'(1) : pos_q + AW'(1);
      if (final_rd) begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      rd_q      <= 1'b0;
      obw_q     <= 1'b0;
      obr_q     <= 1'b0;
      obc_q     <= '0;
    end else begin
      act_q <= act_d;
      rd_q  <= issue;
      if (rd_q) begin
        obw_q <= !obw_q;
      end
      if (pop) begin
        obr_q <= !obr_q;
      end
      obc_q <= obc_after + {1'b0, rd_q};
    end
  end

  // Sequencer payload and read flags
  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    pos_q  <= pos_d;
    rem_q  <= rem_d;
    rev_q  <= rev_d;
    last_q <= last_d;
    if (issue) begin
      rd_run_q  <= final_rd;
      rd_list_q <= final_rd && last_q;
    end
  end

  // Buffer memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem[mem_waddr_i] <= mem_wdata_i;
    end
    if (issue) begin
      rdata_q <= mem[{bank_q, pos_q}];
    end
  end

  // Output stage entries
  assign rext            = {{sgr_pkg::VALUE_W{1'b0}}, rdata_q};
  assign ob_in.out_value = rext[sgr_pkg::VALUE_W-1:0];
  assign ob_in.run_last  = rd_run_q;
  assign ob_in.list_last = rd_list_q;

  always_ff @(posedge clk_i) begin
    if (rd_q) begin
      ob_q[obw_q] <= ob_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stream_group_reverser.sv =====
// Top level of the stream group reverser.
//
//   channel  dir  word contents                         accepted when
//   in_i     in   item_value[15:0], list_end            valid && ready
//   out_o    out  out_value[15:0], run_last, list_last  valid && ready
//   cfg_i    in   group_size[4:0]                       valid (ready tied high)
//
// The front end takes one input word per cycle while its current buffer bank
// is free and the command queue has room; two banks let one group fill while
// the previous one is replayed. The back end loads a group command and then
// reads one word per cycle while the output stage has room; the first result
// word of a group passes through the command queue, the sequencer registers,
// the read data register and the output stage.
// Reset clears counts, bank flags and queues; buffer contents need no clearing.
// Input stalls only when both banks hold groups not yet read out.
`default_nettype none

module stream_group_reverser #(
  parameter int MAX_GROUP  = 16,
  parameter int VALUE_BITS = 16
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  sgr_in_if.sink    in_i,
  sgr_out_if.source out_o,
  sgr_cfg_if.sink   cfg_i
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  sgr_pkg::cmd_t         f_cmd, b_cmd;
  logic                  f_cmd_valid, f_cmd_ready;
  logic                  b_cmd_valid, b_cmd_ready;
  sgr_pkg::rel_t         rel;
  logic                  mem_we;
  logic [AW:0]           mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;

  sgr_front #(
    .MAX_GROUP  (MAX_GROUP),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_cmd_valid),
    .cmd_ready_i (f_cmd_ready),
    .rel_i       (rel),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  sgr_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (f_cmd),
    .push_valid_i (f_cmd_valid),
    .push_ready_o (f_cmd_ready),
    .pop_cmd_o    (b_cmd),
    .pop_valid_o  (b_cmd_valid),
    .pop_ready_i  (b_cmd_ready)
  );

  sgr_back #(
    .MAX_GROUP  (MAX_GROUP),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (b_cmd),
    .cmd_valid_i (b_cmd_valid),
    .cmd_ready_o (b_cmd_ready),
    .rel_o       (rel),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the stream group reverser: directed cases, then random lists.

module testbench;

  localparam int MAX_GROUP    = 16;
  localparam int QUIET_LIMIT  = 2000;  // cycles without any accepted word
  localparam int DRAIN_CYCLES = 16;    // settle time once no result is pending
  localparam int TOTAL_ITEMS  = 130;

  logic clk_i = 1'b0;
  logic rst_ni;

  sgr_in_if  in_ch ();
  sgr_out_if out_ch ();
  sgr_cfg_if cfg_ch ();

  stream_group_reverser #(
    .MAX_GROUP (MAX_GROUP),
    .VALUE_BITS(sgr_pkg::VALUE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Mirror of the block: group size register, held elements, pending results
  logic [sgr_pkg::CFG_W-1:0]   group_size_q;
  logic [sgr_pkg::VALUE_W-1:0] held_values [MAX_GROUP];
  int                          held_count;
  sgr_pkg::out_word_t          expected_words [$];

  int error_count  = 0;
  int quiet_cycles = 0;
  bit steady_flow  = 1'b0;  // no gaps and no stalls while set
  int items_sent   = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Zero counts as one, anything past the buffer depth saturates
  function automatic int active_group_size();
    if (group_size_q == 0) return 1;
    if (group_size_q > MAX_GROUP) return MAX_GROUP;
    return int'(group_size_q);
  endfunction

  // Append one element and queue whatever words it releases
  function automatic void predict_reversal(logic [sgr_pkg::VALUE_W-1:0] value, logic last);
    int                 size;
    sgr_pkg::out_word_t w;
    size = active_group_size();
    if (held_count < MAX_GROUP) begin
      held_values[held_count] = value;
      held_count++;
    end
    if (held_count >= size) begin
      // full group (or more after a size drop): newest first
      for (int i = held_count - 1; i >= 0; i--) begin
        w.out_value = held_values[i];
        w.run_last  = (i == 0);
        w.list_last = last && (i == 0);
        expected_words.push_back(w);
      end
      held_count = 0;
    end else if (last) begin
      // partial group at list end: original order
      for (int i = 0; i < held_count; i++) begin
        w.out_value = held_values[i];
        w.run_last  = (i == held_count - 1);
        w.list_last = (i == held_count - 1);
        expected_words.push_back(w);
      end
      held_count = 0;
    end
  endfunction

  // Send one element; leaves valid high so a back-to-back word needs no toggle
  task automatic send_element(logic [sgr_pkg::VALUE_W-1:0] value, logic last);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.item_value = value;
    in_ch.list_end   = last;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_reversal(value, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop input, wait for every pending result, then let the pipeline settle
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_group_size(logic [sgr_pkg::CFG_W-1:0] size);
    wait_idle();
    cfg_ch.valid      = 1'b1;
    cfg_ch.group_size = size;
    do @(posedge clk_i); while (!cfg_ch.ready);
    group_size_q = size;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Reset value of the size register: pairs swap, odd tail passes in order
  task automatic test_default_size();
    send_element(16'h0000, 1'b0);
    send_element(16'hFFFF, 1'b0);
    send_element(16'hA5A5, 1'b1);
  endtask

  // Size zero acts as one; size one passes every element at once
  task automatic test_size_zero_and_one();
    write_group_size(sgr_pkg::CFG_W'(0));
    send_element(16'h5555, 1'b0);
    send_element(16'hAAAA, 1'b1);
    write_group_size(sgr_pkg::CFG_W'(1));
    send_element(16'h1234, 1'b1);
  endtask

  // Largest register value, short list ends as a partial group
  task automatic test_size_above_max();
    write_group_size(sgr_pkg::CFG_W'(31));
    send_element(16'h8000, 1'b0);
    send_element(16'h0001, 1'b0);
    send_element(16'h7FFF, 1'b1);
  endtask

  // Final element fills the group exactly: reversed, list_last on the last word
  task automatic test_final_completes_group();
    write_group_size(sgr_pkg::CFG_W'(3));
    send_element(16'h0F0F, 1'b0);
    send_element(16'hF0F0, 1'b0);
    send_element(16'hC3C3, 1'b1);
  endtask

  // List shorter than the group size
  task automatic test_short_list();
    write_group_size(sgr_pkg::CFG_W'(4));
    send_element(16'h3C3C, 1'b0);
    send_element(16'h9999, 1'b1);
  endtask

  // Size lowered below the held count: next element flushes everything reversed
  task automatic test_size_lowered_mid_group();
    write_group_size(sgr_pkg::CFG_W'(8));
    send_element(16'h1111, 1'b0);
    send_element(16'h2222, 1'b0);
    send_element(16'h3333, 1'b0);
    write_group_size(sgr_pkg::CFG_W'(2));
    send_element(16'h4444, 1'b0);
    send_element(16'h6666, 1'b1);
  endtask

  // Random lists over random sizes, with an occasional size change inside a list
  task automatic test_random_lists();
    int list_no;
    int size;
    int length;
    list_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       size = $urandom_range(16, 31);
        1:       size = 0;
        default: size = $urandom_range(1, 6);
      endcase
      if (list_no == 0) size = MAX_GROUP;
      if (sgr_pkg::CFG_W'(size) != group_size_q || $urandom_range(0, 2) == 0) begin
        write_group_size(sgr_pkg::CFG_W'(size));
      end
      length = $urandom_range(1, 2 * active_group_size() + 1);
      if (length > TOTAL_ITEMS - items_sent) length = TOTAL_ITEMS - items_sent;
      for (int i = 0; i < length; i++) begin
        if (i > 0 && $urandom_range(0, 15) == 0) begin
          write_group_size(sgr_pkg::CFG_W'($urandom_range(1, 6)));
        end
        send_element(sgr_pkg::VALUE_W'($urandom_range(0, 16'hFFFF)), i == length - 1);
      end
      list_no++;
    end
    steady_flow = 1'b0;
  endtask

  // Result side back-pressure
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  // Result check and watchdog
  always @(posedge clk_i) begin : check_results
    sgr_pkg::out_word_t w;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: out_value %h", out_ch.out_value);
          error_count++;
          $display("RESULT: ERROR");
          $finish;
        end else begin
          w = expected_words.pop_front();
          if (out_ch.out_value !== w.out_value) begin
            $error("out_value: expected %h, got %h", w.out_value, out_ch.out_value);
            error_count++;
          end
          if (out_ch.run_last !== w.run_last) begin
            $error("run_last: expected %b, got %b", w.run_last, out_ch.run_last);
            error_count++;
          end
          if (out_ch.list_last !== w.list_last) begin
            $error("list_last: expected %b, got %b", w.list_last, out_ch.list_last);
            error_count++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.item_value  = '0;
    in_ch.list_end    = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.group_size = '0;
    group_size_q      = sgr_pkg::CFG_W'(2);
    held_count        = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_size();
    test_size_zero_and_one();
    test_size_above_max();
    test_final_completes_group();
    test_short_list();
    test_size_lowered_mid_group();
    test_random_lists();

    wait_idle();
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
